/* rtl/core/teaa_pkg.sv */
// ----------------------------------------------------------------------------
// teaa_pkg
// Shared types and constants of the two-ended arena allocator.
// ----------------------------------------------------------------------------
package teaa_pkg;

   localparam int unsigned ARENA_SIZE_DEFAULT = 6291456;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned ID_W     = 4;
   localparam int unsigned CMD_W    = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 1;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_ARENA_ID = 1'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT       = 3'd0,
      CMD_ALLOC_LOW  = 3'd1,
      CMD_ALLOC_HIGH = 3'd2,
      CMD_SET_LOW    = 3'd3,
      CMD_SET_HIGH   = 3'd4,
      CMD_GET_LOW    = 3'd5,
      CMD_GET_HIGH   = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_BAD   = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

/* rtl/core/teaa_req_if.sv */
// ----------------------------------------------------------------------------
// teaa_req_if
// Request channel of the arena allocator: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface teaa_req_if
   import teaa_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ID_W-1:0]     arena_id;
   logic [ADDR_W-1:0]   request_size;
   logic [ADDR_W-1:0]   alignment;
   logic [ADDR_W-1:0]   new_pointer;

   modport source (output valid, command, arena_id, request_size, alignment,
                   new_pointer, input ready);
   modport sink   (input valid, command, arena_id, request_size, alignment,
                   new_pointer, output ready);
endinterface

/* rtl/core/teaa_rsp_if.sv */
// ----------------------------------------------------------------------------
// teaa_rsp_if
// Response channel of the arena allocator: valid/ready plus address, status.
// ----------------------------------------------------------------------------
interface teaa_rsp_if
   import teaa_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, address, status, input ready);
   modport sink   (input valid, address, status, output ready);
endinterface

/* rtl/core/two_ended_arena_allocator.sv */
// ----------------------------------------------------------------------------
// two_ended_arena_allocator
// Double-ended bump allocator over one fixed arena, one request per cycle unless the response is stalled.
// ----------------------------------------------------------------------------
// The block keeps a low and a high pointer into one arena of ARENA_SIZE bytes
// starting at csr register arena_base, and serves init, allocate-from-low,
// allocate-from-high, set-low, set-high and get-bound requests. Every request
// gives exactly one response. A request is taken on req_bus when valid and
// ready are high; it sits in the input register, where the pointer update
// and the response are worked out, and the response is then held in the
// output register until rsp_bus.ready. Throughput is one request per clock
// while rsp_bus.ready stays high. Both stages move together, so a new request
// is taken into an empty input register while a finished response waits, and
// back-to-back requests see each other's pointer updates.
// An error (status not ok) returns address 0 and leaves the pointers alone.
// The csr registers (index 0 arena_base, index 1 main_arena_id) are written
// with csr_wr_en and may only change while no request is in flight.
// ----------------------------------------------------------------------------
module two_ended_arena_allocator
   import teaa_pkg::*;
#(
   parameter int unsigned ARENA_SIZE = ARENA_SIZE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   teaa_req_if.sink             req_bus,
   teaa_rsp_if.source           rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   localparam logic [ADDR_W:0] SIZE_WIDE = (ADDR_W+1)'(ARENA_SIZE);

   // csr registers
   logic [ADDR_W-1:0] base_ff;
   logic [ID_W-1:0]   main_id_ff;

   // allocator state
   logic [ADDR_W-1:0] low_ff,  low_in;
   logic [ADDR_W-1:0] high_ff, high_in;

   // input register; alignment is pre-decoded to a mask and a legality bit
   logic              in_vld_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [ADDR_W-1:0] size_ff;
   logic [ADDR_W-1:0] mask_ff;
   logic              align_ok_ff;
   logic [ADDR_W-1:0] ptr_ff;

   // output register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [ADDR_W-1:0]   addr_ff,   addr_in;
   status_type          status_ff, status_in;

   logic              advance;
   logic              take;
   logic [ADDR_W-1:0] req_mask;

   // arena bounds
   logic [ADDR_W:0]   end_wide;
   logic [ADDR_W-1:0] end_sat;
   logic              id_ok;

   // alloc low datapath
   logic [ADDR_W:0]   lo_round;
   logic [ADDR_W:0]   lo_start;
   logic [ADDR_W+1:0] lo_end;

   // alloc high datapath
   logic              hi_inverted;
   logic [ADDR_W-1:0] hi_room;
   logic [ADDR_W-1:0] hi_start;

   // handshake: both stages step together
   assign advance       = in_vld_ff && (!rsp_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !in_vld_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;
   assign req_mask      = req_bus.alignment - ADDR_W'(1);

   assign rsp_bus.valid   = rsp_vld_ff;
   assign rsp_bus.address = addr_ff;
   assign rsp_bus.status  = status_ff;

   assign end_wide = {1'b0, base_ff} + SIZE_WIDE;
   assign end_sat  = end_wide[ADDR_W] ? '1 : end_wide[ADDR_W-1:0];
   assign id_ok    = (id_ff == main_id_ff);

   // round low up, then check the block end against high (one bit of headroom)
   assign lo_round = {1'b0, low_ff} + {1'b0, mask_ff};
   assign lo_start = lo_round & {1'b1, ~mask_ff};
   assign lo_end   = {1'b0, lo_start} + {2'b00, size_ff};

   assign hi_inverted = (high_ff < low_ff);
   assign hi_room     = high_ff - low_ff;
   assign hi_start    = (high_ff - size_ff) & ~mask_ff;

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      addr_in   = '0;
      status_in = ST_OK;
      case (cmd_type'(cmd_ff))
         CMD_INIT: begin
            low_in  = base_ff;
            high_in = end_sat;
         end
         CMD_ALLOC_LOW: begin
            if (!id_ok || !align_ok_ff) begin
               status_in = ST_BAD;
            end else if (lo_end > {2'b00, high_ff}) begin
               status_in = ST_NOMEM;
            end else begin
               low_in  = lo_end[ADDR_W-1:0];
               addr_in = lo_start[ADDR_W-1:0];
            end
         end
         CMD_ALLOC_HIGH: begin
            if (!id_ok || !align_ok_ff) begin
               status_in = ST_BAD;
            end else if (hi_inverted || size_ff > hi_room) begin
               status_in = ST_NOMEM;
            end else if (hi_start < low_ff) begin
               status_in = ST_NOMEM;
            end else begin
               high_in = hi_start;
               addr_in = hi_start;
            end
         end
         CMD_SET_LOW: begin
            if (!id_ok) begin
               status_in = ST_BAD;
            end else if (ptr_ff < base_ff || ptr_ff > high_ff) begin
               status_in = ST_RANGE;
            end else begin
               low_in = ptr_ff;
            end
         end
         CMD_SET_HIGH: begin
            if (!id_ok) begin
               status_in = ST_BAD;
            end else if (ptr_ff < low_ff || {1'b0, ptr_ff} > end_wide) begin
               status_in = ST_RANGE;
            end else begin
               high_in = ptr_ff;
            end
         end
         CMD_GET_LOW: begin
            if (!id_ok) status_in = ST_BAD;
            else        addr_in   = base_ff;
         end
         CMD_GET_HIGH: begin
            if (!id_ok) status_in = ST_BAD;
            else        addr_in   = end_sat;
         end
         default: begin
            status_in = ST_BAD;
         end
      endcase
   end

   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_bus.ready);

   // control state and csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         low_ff     <= '0;
         high_ff    <= '0;
         base_ff    <= '0;
         main_id_ff <= '0;
      end else begin
         if (req_bus.ready) in_vld_ff <= req_bus.valid;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            low_ff  <= low_in;
            high_ff <= high_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ARENA_BASE:    base_ff    <= csr_wdata;
               CSR_MAIN_ARENA_ID: main_id_ff <= csr_wdata[ID_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff      <= req_bus.command;
         id_ff       <= req_bus.arena_id;
         size_ff     <= req_bus.request_size;
         mask_ff     <= req_mask;
         align_ok_ff <= (req_bus.alignment != '0) &&
                        ((req_bus.alignment & req_mask) == '0);
         ptr_ff      <= req_bus.new_pointer;
      end
      if (advance) begin
         addr_ff   <= addr_in;
         status_ff <= status_in;
      end
   end

   // errors never carry an address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (status_ff != ST_OK) |-> (addr_ff == '0))
      else $error("error response with nonzero address");

   // pointers only move when a request is retired
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(low_ff) && $stable(high_ff)))
      else $error("pointer changed without a retiring request");

   // a granted low allocation never moves low backward
   a_low_grows: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_ff == CMD_ALLOC_LOW) && (status_in == ST_OK)
      |=> (low_ff >= $past(low_ff)))
      else $error("low pointer moved backward on alloc");

   // a granted high allocation never raises high
   a_high_drops: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_ff == CMD_ALLOC_HIGH) && (status_in == ST_OK)
      |=> (high_ff <= $past(high_ff)))
      else $error("high pointer moved up on alloc");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_vld_ff && !rsp_vld_ff))
      else $error("pipeline not empty after reset");

endmodule
